[design/ssl_pkg.sv]
// Shared constants and types for the sorted set lookup/remove block.
package ssl_pkg;

  localparam int SET_DEPTH  = 32;
  localparam int VALUE_BITS = 16;
  localparam int CNT_W      = $clog2(SET_DEPTH + 1);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_W-1:0]      count_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic   load;
    logic   remove;
  } cell_cmd_t;

  // Per-cell compare flags against the broadcast value.
  typedef struct packed {
    logic le;
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

[design/ssl_if.sv]
// Request and response channel interfaces.
interface ssl_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] value;
  logic [15:0] requester_tag;

  modport source (output valid, req_type, value, requester_tag, input ready);
  modport sink   (input valid, req_type, value, requester_tag, output ready);
endinterface

interface ssl_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [5:0]  remaining;
  logic        status;
  logic [15:0] reply_tag;

  modport source (output valid, hit, remaining, status, reply_tag, input ready);
  modport sink   (input valid, hit, remaining, status, reply_tag, output ready);
endinterface

[design/ssl_cell.sv]
// One slot of the sorted chain: holds a value, shifts up on insert, down on remove.
module ssl_cell
  import ssl_pkg::*;
(
  input  logic        clk,
  input  cell_cmd_t   cmd,
  input  value_t      key,
  input  logic        live,
  input  logic        left_le,
  input  value_t      left_data,
  input  value_t      right_data,
  output value_t      data,
  output cell_flags_t flags
);

  value_t data_next;

  always_comb begin
    flags.le = live && (data <= key);
    flags.lt = live && (data <  key);
    flags.eq = live && (data == key);
  end

  always_comb begin
    data_next = data;
    if (cmd.load) begin
      if (!flags.le) begin
        data_next = left_le ? key : left_data;
      end
    end else if (cmd.remove) begin
      if (!flags.lt) begin
        data_next = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[design/sorted_set_lookup_remove.sv]
// Sorted multiset with insert and search-and-remove, built as a chain of cells.
// Response valid rises in the cycle after the request transaction.
// Throughput: 1 request per cycle while responses are taken; every cell compares and shifts in the same cycle.
// The response register frees whenever it is taken, so a new request enters alongside.
// Reset (synchronous, rst high) empties the set and drops any pending response.
// Slot contents are not cleared; slots at or above the fill count never affect a compare.
module sorted_set_lookup_remove
  import ssl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ssl_req_if.sink   req,
  ssl_rsp_if.source rsp
);

  count_t      count;
  count_t      count_next;
  value_t      data  [SET_DEPTH];
  cell_flags_t flags [SET_DEPTH];
  logic [SET_DEPTH-1:0] eq_vec;
  cell_cmd_t   cmd;
  value_t      key;
  logic        accept;
  logic        full;
  logic        hit;
  logic        out_valid;

  assign full   = (count == count_t'(SET_DEPTH));
  assign accept = req.valid && req.ready;
  assign req.ready = !out_valid || rsp.ready;

  always_comb begin
    for (int i = 0; i < SET_DEPTH; i++) begin
      eq_vec[i] = flags[i].eq;
    end
  end

  assign hit = |eq_vec;

  assign key        = req.value[VALUE_BITS-1:0];
  assign cmd.load   = accept && (req.req_type == REQ_LOAD) && !full;
  assign cmd.remove = accept && (req.req_type == REQ_QUERY) && hit;

  always_comb begin
    count_next = count;
    if (cmd.load) begin
      count_next = count + count_t'(1);
    end else if (cmd.remove) begin
      count_next = count - count_t'(1);
    end
  end

  for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
    logic   live;
    logic   left_le;
    value_t left_data;
    value_t right_data;

    assign live = (count > count_t'(i));

    if (i == 0) begin : g_first
      assign left_le   = 1'b1;
      assign left_data = key;
    end else begin : g_mid
      assign left_le   = flags[i-1].le;
      assign left_data = data[i-1];
    end

    if (i == SET_DEPTH - 1) begin : g_last
      assign right_data = data[i];
    end else begin : g_inner
      assign right_data = data[i+1];
    end

    ssl_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .key        (key),
      .live       (live),
      .left_le    (left_le),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (data[i]),
      .flags      (flags[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.hit       <= (req.req_type == REQ_QUERY) && hit;
      rsp.remaining <= 6'(count_next);
      rsp.status    <= ((req.req_type == REQ_LOAD) && full) ? STATUS_FULL : STATUS_OK;
      rsp.reply_tag <= req.requester_tag;
    end
  end

  assign rsp.valid = out_valid;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(SET_DEPTH))
    else $error("fill count above depth");

  a_remaining_tracks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rsp.remaining == 6'(count))
    else $error("response count differs from fill count");

  a_hit_xor_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(rsp.hit && rsp.status == STATUS_FULL))
    else $error("hit and full status together");

  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rsp.status == STATUS_FULL) |-> full)
    else $error("load rejected while not full");

  a_hit_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.remove |=> count == $past(count) - count_t'(1))
    else $error("remove did not shrink set");

endmodule
